// File: design/assert_macros.svh
// Assertion macros used by the checker file lcm_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in this cycle, consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent holds in this cycle, consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/lcm_pkg.sv
// Package for the lcm unit: widths, defaults and controller/datapath link types.
`default_nettype none

package lcm_pkg;

  localparam int IN_BITS          = 32;
  localparam int MULT_BITS        = 64;
  localparam int DIV_BITS         = 32;
  localparam int OPERAND_BITS_DEF = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic strip_step;
    logic gcd_step;
    logic gcd_fin;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero;
    logic both_even;
    logic equal;
    logic cnt_last;
  } stat_t;

endpackage

`default_nettype wire

// File: design/lcm_unit.sv
// Top level of the lcm unit: controller plus datapath.
//
// Input channel: operand_a, operand_b with in_valid / in_ready. A beat is
// taken when both are high; only the low OPERAND_BITS of each operand count.
// Output channel: multiple (exact 64-bit lcm), divisor (gcd) and zero_operand
// with out_valid / out_ready. Either operand zero gives 0, 0 and the flag.
// One item is worked at a time. After a beat is taken, removing common
// factors of two and the binary gcd steps come first, then OPERAND_BITS
// divider steps for a/gcd, OPERAND_BITS shift-add steps for the product
// and the handoffs between phases, all on one shared datapath. A zero
// operand goes from the strip phase straight to the output handoff.
// Results sit in an output register, so a new beat is taken while the last
// result waits. If the receiver stalls, a finished item waits in the
// sequencer until the output register frees, and no further beat is taken.
// Synchronous reset returns the sequencer to idle and drops out_valid.
`default_nettype none

module lcm_unit #(
  parameter int OPERAND_BITS = lcm_pkg::OPERAND_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [lcm_pkg::IN_BITS-1:0] operand_a,
  input  wire logic [lcm_pkg::IN_BITS-1:0] operand_b,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [lcm_pkg::MULT_BITS-1:0]    multiple,
  output logic [lcm_pkg::DIV_BITS-1:0]     divisor,
  output logic                             zero_operand
);
  import lcm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lcm_dp #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk          (clk),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .cmd          (cmd),
    .stat         (stat),
    .multiple     (multiple),
    .divisor      (divisor),
    .zero_operand (zero_operand)
  );

endmodule

`default_nettype wire

// File: design/lcm_ctrl.sv
// Sequencer for the lcm unit: strip, gcd, divide, multiply, hand off.
`default_nettype none

module lcm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire lcm_pkg::stat_t stat,
  output lcm_pkg::cmd_t      cmd
);
  import lcm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STRIP,
    S_GCD,
    S_DIV,
    S_MULI,
    S_MUL,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_STRIP;
        end
      end
      S_STRIP: begin
        if (stat.zero) begin
          state_next = S_DONE;
        end else if (stat.both_even) begin
          cmd.strip_step = 1'b1;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.equal) begin
          cmd.gcd_fin = 1'b1;
          state_next  = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.cnt_last) state_next = S_MULI;
      end
      S_MULI: begin
        cmd.mul_init = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.cnt_last) state_next = S_DONE;
      end
      S_DONE: begin
        // output register free, or its beat leaves this cycle
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/lcm_dp.sv
// Datapath for the lcm unit: binary gcd, restoring divider, shift-add multiplier.
`default_nettype none

module lcm_dp #(
  parameter int OPERAND_BITS = lcm_pkg::OPERAND_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic [lcm_pkg::IN_BITS-1:0]   operand_a,
  input  wire logic [lcm_pkg::IN_BITS-1:0]   operand_b,
  input  wire lcm_pkg::cmd_t                 cmd,
  output lcm_pkg::stat_t                     stat,
  output logic [lcm_pkg::MULT_BITS-1:0]      multiple,
  output logic [lcm_pkg::DIV_BITS-1:0]       divisor,
  output logic                               zero_operand
);
  import lcm_pkg::*;

  localparam int W  = OPERAND_BITS;
  localparam int KW = $clog2(W);

  logic [W-1:0]  a_in;
  logic [W-1:0]  b_in;
  logic [W-1:0]  ra;
  logic [W-1:0]  rb;
  logic [W-1:0]  x;
  logic [W-1:0]  y;
  logic [KW-1:0] k;
  logic [W-1:0]  g;
  logic [W-1:0]  rem;
  logic [W-1:0]  q;
  logic [W-1:0]  hi;
  logic [W-1:0]  lo;
  logic [KW-1:0] cnt;
  logic          zero;

  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          ge;
  logic [W:0]    sum;

  assign a_in = operand_a[W-1:0];
  assign b_in = operand_b[W-1:0];

  assign stat.zero      = zero;
  assign stat.both_even = !x[0] && !y[0];
  assign stat.equal     = (x == y);
  assign stat.cnt_last  = (cnt == KW'(W - 1));

  // restoring divide step: remainder stays below g
  assign rem_sh = {rem, q[W-1]};
  assign diff   = rem_sh - {1'b0, g};
  assign ge     = !diff[W];

  // multiply step: add b when the low multiplier bit is set, then shift right
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, rb} : {(W + 1){1'b0}});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ra   <= a_in;
      rb   <= b_in;
      x    <= a_in;
      y    <= b_in;
      k    <= '0;
      zero <= (a_in == '0) || (b_in == '0);
    end
    if (cmd.strip_step) begin
      x <= x >> 1;
      y <= y >> 1;
      k <= k + 1'b1;
    end
    if (cmd.gcd_step) begin
      if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x > y) begin
        x <= (x - y) >> 1;
      end else begin
        y <= (y - x) >> 1;
      end
    end
    if (cmd.gcd_fin) begin
      g   <= x << k;
      rem <= '0;
      q   <= ra;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      q   <= {q[W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
    if (cmd.mul_init) begin
      hi  <= '0;
      lo  <= q;
      cnt <= '0;
    end
    if (cmd.mul_step) begin
      hi  <= sum[W:1];
      lo  <= {sum[0], lo[W-1:1]};
      cnt <= cnt + 1'b1;
    end
    if (cmd.out_load) begin
      zero_operand <= zero;
      if (zero) begin
        multiple <= '0;
        divisor  <= '0;
      end else begin
        multiple <= MULT_BITS'({hi, lo});
        divisor  <= DIV_BITS'(g);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/lcm_chk.sv
// Port-level checker for the lcm unit and its bind.
`default_nettype none
`include "assert_macros.svh"

module lcm_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [lcm_pkg::IN_BITS-1:0] operand_a,
  input wire logic [lcm_pkg::IN_BITS-1:0] operand_b,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [lcm_pkg::MULT_BITS-1:0] multiple,
  input wire logic [lcm_pkg::DIV_BITS-1:0]  divisor,
  input wire logic                        zero_operand
);

  // a stalled result beat stays put
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(multiple))
  // zero flag forces both results to zero
  `ASSERT_SAME(a_zero_res, clk, rst, out_valid && zero_operand, multiple == '0 && divisor == '0)
  // the gcd and the lcm of nonzero operands are never zero
  `ASSERT_SAME(a_gcd_nz, clk, rst, out_valid && !zero_operand, divisor != '0 && multiple != '0)
  // one item in flight: input closes right after a beat is taken
  `ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind lcm_unit lcm_chk u_chk (.*);

`default_nettype wire
